// ===== sv/discovery_frame_responder_assert.svh =====
// Assertion macros for the discovery frame responder checker.
// Used by dfr_checker; needs i_clk and i_rst_n in scope.
`ifndef DISCOVERY_FRAME_RESPONDER_ASSERT_SVH
`define DISCOVERY_FRAME_RESPONDER_ASSERT_SVH

// same-cycle implication
`define DFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dfr_pkg.sv =====
// Shared types and constants of the discovery frame responder.
// Used by dfr_ctrl, dfr_dp and the top level.
package dfr_pkg;

    localparam int HDR_LEN    = 16;
    localparam int HEAD_DEPTH = 13;
    localparam int ID_PAYLOAD = 22;
    localparam int TDATA_W    = 120;
    localparam int PADDR_W    = 6;

    localparam logic [7:0] RESP_BIT     = 8'h80;
    localparam logic [7:0] VERSION      = 8'h01;
    localparam logic [7:0] LED_DEFAULT  = 8'd10;
    localparam logic [7:0] OP_IDENTIFY  = 8'h01;
    localparam logic [7:0] OP_SET_NET   = 8'h02;
    localparam logic [7:0] OP_SET_NAME  = 8'h03;
    localparam logic [7:0] OP_FLASH_LED = 8'h04;
    localparam logic [7:0] OP_REBOOT    = 8'h05;
    localparam logic [7:0] OP_FACTORY   = 8'h06;

    localparam logic [1:0] MODE_STATIC    = 2'd0;
    localparam logic [1:0] MODE_LINKLOCAL = 2'd2;

    localparam logic [7:0] ST_OK  = 8'd0;
    localparam logic [7:0] ST_ERR = 8'd1;

    localparam logic [31:0] LL_MASK = 32'hFFFF_0000;

    localparam logic [2:0] REG_MAC   = 3'd0;
    localparam logic [2:0] REG_LL    = 3'd1;
    localparam logic [2:0] REG_PROD  = 3'd2;
    localparam logic [2:0] REG_HWREV = 3'd3;
    localparam logic [2:0] REG_FWVER = 3'd4;
    localparam logic [2:0] REG_IP    = 3'd5;
    localparam logic [2:0] REG_MASK  = 3'd6;
    localparam logic [2:0] REG_GW    = 3'd7;

    typedef struct packed {
        logic accept;
        logic eval;
        logic load;
        logic last;
    } t_cmd;

    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        logic [7:0] m;
        case (pos)
            2'd0:    m = 8'h50;
            2'd1:    m = 8'h4C;
            2'd2:    m = 8'h43;
            default: m = 8'h44;
        endcase
        return m;
    endfunction

endpackage

// ===== sv/dfr_ctrl.sv =====
// Controller of the discovery frame responder: receive, evaluate, transmit.
// Depends on dfr_pkg; drives dfr_dp through t_cmd.
module dfr_ctrl #(
    parameter int IDX_W = 6,
    parameter int LEN_W = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rx_valid,
    input  logic               i_rx_last,
    input  logic               i_tx_ready,
    input  logic [LEN_W-1:0]   i_reply_len,
    output logic               o_rx_ready,
    output logic               o_tx_valid,
    output logic               o_tx_last,
    output logic [IDX_W-1:0]   o_idx,
    output dfr_pkg::t_cmd      o_cmd
);

    typedef enum logic [1:0] {S_RX, S_EVAL, S_TX} t_state;

    t_state             r_state;
    logic               r_valid;
    logic               r_last;
    logic [IDX_W-1:0]   r_idx;
    logic [LEN_W-1:0]   r_len;
    logic               n_load;
    logic               n_fin;

    assign o_rx_ready = (r_state == S_RX);
    assign n_load     = (r_state == S_TX) && (!r_valid || i_tx_ready);
    assign n_fin      = (LEN_W'(r_idx) == LEN_W'(r_len - LEN_W'(1)));

    always_comb begin
        o_cmd.accept = o_rx_ready && i_rx_valid;
        o_cmd.eval   = (r_state == S_EVAL);
        o_cmd.load   = n_load;
        o_cmd.last   = n_fin;
    end

    assign o_tx_valid = r_valid;
    assign o_tx_last  = r_last;
    assign o_idx      = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RX;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            r_idx   <= '0;
            r_len   <= '0;
        end else begin
            if (n_load) begin
                r_valid <= 1'b1;
                r_last  <= n_fin;
            end else if (i_tx_ready) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_RX: begin
                    if (i_rx_valid && i_rx_last) r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_len <= i_reply_len;
                    r_idx <= '0;
                    r_state <= (i_reply_len != '0) ? S_TX : S_RX;
                end
                S_TX: begin
                    if (n_load) begin
                        if (n_fin) begin
                            r_idx   <= '0;
                            r_state <= S_RX;
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end
                end
                default: r_state <= S_RX;
            endcase
        end
    end

endmodule

// ===== sv/dfr_dp.sv =====
// Datapath of the discovery frame responder: register file, header capture,
// request decode, network state and reply byte generation. Depends on dfr_pkg.
module dfr_dp #(
    parameter int RX_BUFFER_BYTES = 128,
    parameter int NAME_BYTES      = 16,
    parameter int IDX_W           = 6,
    parameter int LEN_W           = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dfr_pkg::t_cmd                i_cmd,
    input  logic [IDX_W-1:0]             i_idx,
    input  logic [7:0]                   i_rx_byte,
    input  logic                         i_cfg_we,
    input  logic [2:0]                   i_cfg_idx,
    input  logic [63:0]                  i_cfg_wdata,
    output logic [63:0]                  o_cfg_rdata,
    output logic [LEN_W-1:0]             o_reply_len,
    output logic [dfr_pkg::TDATA_W-1:0]  o_tdata
);

    localparam int ID_LEN  = dfr_pkg::ID_PAYLOAD + NAME_BYTES;
    localparam int TOT_LEN = dfr_pkg::HDR_LEN + ID_LEN;

    logic [47:0] r_mac;
    logic [31:0] r_ll, r_prod, r_iip, r_imask, r_igw;
    logic [15:0] r_hwrev, r_fwver;

    logic [7:0]  r_cnt;
    logic        r_bad;
    logic [7:0]  r_op;
    logic [15:0] r_tid;
    logic [47:0] r_tmac;
    logic [15:0] r_dlen;
    logic [7:0]  r_head [dfr_pkg::HEAD_DEPTH];

    logic [31:0] r_ip, r_mask, r_gw;
    logic        r_ovr;
    logic [1:0]  r_mode;

    logic        r_ident;
    logic [7:0]  r_status;
    logic        r_chg, r_led, r_rbt;
    logic [7:0]  r_secs;
    logic [7:0]  r_rop;
    logic [15:0] r_rtid;
    logic [dfr_pkg::TDATA_W-1:0] r_tdata;

    logic        n_ok;
    logic [7:0]  n_avail;
    logic [7:0]  n_plen;
    logic [LEN_W-1:0] n_len;
    logic        n_ident, n_chg, n_ll, n_st, n_led, n_rbt;
    logic [7:0]  n_status, n_secs;
    logic [7:0]  n_byte;
    logic [7:0]  n_pos;
    logic [IDX_W-1:0] n_p;
    logic [31:0] n_rip, n_rmask, n_rgw;
    logic [15:0] n_hplen;
    logic [dfr_pkg::TDATA_W-1:0] n_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac <= '0; r_ll <= '0; r_prod <= '0; r_hwrev <= '0; r_fwver <= '0;
            r_iip <= '0; r_imask <= '0; r_igw <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dfr_pkg::REG_MAC:   r_mac   <= i_cfg_wdata[47:0];
                dfr_pkg::REG_LL:    r_ll    <= i_cfg_wdata[31:0];
                dfr_pkg::REG_PROD:  r_prod  <= i_cfg_wdata[31:0];
                dfr_pkg::REG_HWREV: r_hwrev <= i_cfg_wdata[15:0];
                dfr_pkg::REG_FWVER: r_fwver <= i_cfg_wdata[15:0];
                dfr_pkg::REG_IP:    r_iip   <= i_cfg_wdata[31:0];
                dfr_pkg::REG_MASK:  r_imask <= i_cfg_wdata[31:0];
                dfr_pkg::REG_GW:    r_igw   <= i_cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_cfg_idx)
            dfr_pkg::REG_MAC:   o_cfg_rdata = {16'd0, r_mac};
            dfr_pkg::REG_LL:    o_cfg_rdata = {32'd0, r_ll};
            dfr_pkg::REG_PROD:  o_cfg_rdata = {32'd0, r_prod};
            dfr_pkg::REG_HWREV: o_cfg_rdata = {48'd0, r_hwrev};
            dfr_pkg::REG_FWVER: o_cfg_rdata = {48'd0, r_fwver};
            dfr_pkg::REG_IP:    o_cfg_rdata = {32'd0, r_iip};
            dfr_pkg::REG_MASK:  o_cfg_rdata = {32'd0, r_imask};
            dfr_pkg::REG_GW:    o_cfg_rdata = {32'd0, r_igw};
            default:            o_cfg_rdata = '0;
        endcase
    end

    // request decode, valid in the evaluate cycle
    always_comb begin
        n_ok = (r_cnt >= 8'(dfr_pkg::HDR_LEN)) && !r_bad && !r_op[7]
            && ((r_tmac == '0) || (r_tmac == r_mac));
        n_avail = r_cnt - 8'(dfr_pkg::HDR_LEN);
        n_plen  = (r_dlen > {8'd0, n_avail}) ? n_avail : r_dlen[7:0];
        n_ll    = (n_plen >= 8'd1) && (r_head[0] == 8'(dfr_pkg::MODE_LINKLOCAL));
        n_st    = (n_plen >= 8'(dfr_pkg::HEAD_DEPTH))
            && (r_head[0] == 8'(dfr_pkg::MODE_STATIC));
        n_ident = 1'b0; n_chg = 1'b0; n_led = 1'b0; n_rbt = 1'b0;
        n_status = dfr_pkg::ST_OK;
        n_secs   = '0;
        n_len    = '0;
        if (n_ok) begin
            case (r_op)
                dfr_pkg::OP_IDENTIFY: begin
                    n_ident = 1'b1;
                    n_len   = LEN_W'(TOT_LEN);
                end
                dfr_pkg::OP_SET_NET: begin
                    n_chg    = n_ll || n_st;
                    n_status = (n_ll || n_st) ? dfr_pkg::ST_OK : dfr_pkg::ST_ERR;
                    n_len    = LEN_W'(dfr_pkg::HDR_LEN + 1);
                end
                dfr_pkg::OP_FLASH_LED: begin
                    n_led  = 1'b1;
                    n_secs = (n_plen >= 8'd1) ? r_head[0] : dfr_pkg::LED_DEFAULT;
                    n_len  = LEN_W'(dfr_pkg::HDR_LEN + 1);
                end
                dfr_pkg::OP_REBOOT: begin
                    n_rbt = 1'b1;
                    n_len = LEN_W'(dfr_pkg::HDR_LEN + 1);
                end
                dfr_pkg::OP_SET_NAME, dfr_pkg::OP_FACTORY: begin
                    n_status = dfr_pkg::ST_ERR;
                    n_len    = LEN_W'(dfr_pkg::HDR_LEN + 1);
                end
                default: n_len = '0;
            endcase
        end
    end

    assign o_reply_len = n_len;
    assign n_pos = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_bad <= 1'b0; r_op <= '0; r_tid <= '0;
            r_tmac <= '0; r_dlen <= '0;
            r_ip <= '0; r_mask <= '0; r_gw <= '0;
            r_ovr <= 1'b0; r_mode <= dfr_pkg::MODE_LINKLOCAL;
            r_ident <= 1'b0; r_status <= '0;
            r_chg <= 1'b0; r_led <= 1'b0; r_rbt <= 1'b0; r_secs <= '0;
            r_rop <= '0; r_rtid <= '0;
        end else if (i_cmd.eval) begin
            r_ident  <= n_ident;
            r_status <= n_status;
            r_chg    <= n_chg;
            r_led    <= n_led;
            r_rbt    <= n_rbt;
            r_secs   <= n_secs;
            r_rop    <= r_op;
            r_rtid   <= r_tid;
            if (n_ok && (r_op == dfr_pkg::OP_SET_NET) && (n_ll || n_st)) begin
                r_ovr <= 1'b1;
                if (n_ll) begin
                    r_ip   <= r_ll;
                    r_mask <= dfr_pkg::LL_MASK;
                    r_gw   <= '0;
                    r_mode <= dfr_pkg::MODE_LINKLOCAL;
                end else begin
                    r_ip   <= {r_head[1], r_head[2], r_head[3], r_head[4]};
                    r_mask <= {r_head[5], r_head[6], r_head[7], r_head[8]};
                    r_gw   <= {r_head[9], r_head[10], r_head[11], r_head[12]};
                    r_mode <= dfr_pkg::MODE_STATIC;
                end
            end
            r_cnt <= '0; r_bad <= 1'b0; r_op <= '0; r_tid <= '0;
            r_tmac <= '0; r_dlen <= '0;
        end else if (i_cmd.accept && (n_pos < 8'(RX_BUFFER_BYTES))) begin
            if (n_pos < 8'd4) begin
                if (i_rx_byte != dfr_pkg::magic_byte(n_pos[1:0])) r_bad <= 1'b1;
            end else if (n_pos == 8'd4) begin
                if (i_rx_byte != dfr_pkg::VERSION) r_bad <= 1'b1;
            end else if (n_pos == 8'd5) begin
                r_op <= i_rx_byte;
            end else if (n_pos < 8'd8) begin
                r_tid <= {r_tid[7:0], i_rx_byte};
            end else if (n_pos < 8'd14) begin
                r_tmac <= {r_tmac[39:0], i_rx_byte};
            end else if (n_pos < 8'(dfr_pkg::HDR_LEN)) begin
                r_dlen <= {r_dlen[7:0], i_rx_byte};
            end
            r_cnt <= n_pos + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (n_pos >= 8'(dfr_pkg::HDR_LEN))
            && (n_pos < 8'(dfr_pkg::HDR_LEN + dfr_pkg::HEAD_DEPTH))) begin
            r_head[4'(n_pos - 8'(dfr_pkg::HDR_LEN))] <= i_rx_byte;
        end
    end

    // reply byte at index i_idx
    always_comb begin
        n_rip   = r_ovr ? r_ip   : r_iip;
        n_rmask = r_ovr ? r_mask : r_imask;
        n_rgw   = r_ovr ? r_gw   : r_igw;
        n_hplen = r_ident ? 16'(ID_LEN) : 16'd1;
        n_p     = i_idx - IDX_W'(dfr_pkg::HDR_LEN);
        n_byte  = '0;
        if (i_idx < IDX_W'(dfr_pkg::HDR_LEN)) begin
            case (i_idx[3:0])
                4'd0, 4'd1, 4'd2, 4'd3: n_byte = dfr_pkg::magic_byte(i_idx[1:0]);
                4'd4:  n_byte = dfr_pkg::VERSION;
                4'd5:  n_byte = r_rop | dfr_pkg::RESP_BIT;
                4'd6:  n_byte = r_rtid[15:8];
                4'd7:  n_byte = r_rtid[7:0];
                4'd8:  n_byte = r_mac[47:40];
                4'd9:  n_byte = r_mac[39:32];
                4'd10: n_byte = r_mac[31:24];
                4'd11: n_byte = r_mac[23:16];
                4'd12: n_byte = r_mac[15:8];
                4'd13: n_byte = r_mac[7:0];
                4'd14: n_byte = n_hplen[15:8];
                default: n_byte = n_hplen[7:0];
            endcase
        end else if (!r_ident) begin
            n_byte = (n_p == '0) ? r_status : 8'd0;
        end else if (n_p < IDX_W'(dfr_pkg::ID_PAYLOAD)) begin
            case (n_p[4:0])
                5'd0:  n_byte = r_prod[31:24];
                5'd1:  n_byte = r_prod[23:16];
                5'd2:  n_byte = r_prod[15:8];
                5'd3:  n_byte = r_prod[7:0];
                5'd4:  n_byte = r_hwrev[15:8];
                5'd5:  n_byte = r_hwrev[7:0];
                5'd6:  n_byte = r_fwver[15:8];
                5'd7:  n_byte = r_fwver[7:0];
                5'd8:  n_byte = {6'd0, r_mode};
                5'd9:  n_byte = 8'd1;
                5'd10: n_byte = n_rip[31:24];
                5'd11: n_byte = n_rip[23:16];
                5'd12: n_byte = n_rip[15:8];
                5'd13: n_byte = n_rip[7:0];
                5'd14: n_byte = n_rmask[31:24];
                5'd15: n_byte = n_rmask[23:16];
                5'd16: n_byte = n_rmask[15:8];
                5'd17: n_byte = n_rmask[7:0];
                5'd18: n_byte = n_rgw[31:24];
                5'd19: n_byte = n_rgw[23:16];
                5'd20: n_byte = n_rgw[15:8];
                5'd21: n_byte = n_rgw[7:0];
                default: n_byte = 8'd0;
            endcase
        end
    end

    always_comb begin
        n_tdata = '0;
        n_tdata[7:0] = n_byte;
        if (i_cmd.last) begin
            n_tdata[8] = r_chg;
            if (r_chg) begin
                n_tdata[40:9]    = r_ip;
                n_tdata[72:41]   = r_mask;
                n_tdata[104:73]  = r_gw;
                n_tdata[106:105] = r_mode;
            end
            n_tdata[107]     = r_led;
            n_tdata[115:108] = r_led ? r_secs : 8'd0;
            n_tdata[116]     = r_rbt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tdata <= n_tdata;
        end
    end

    assign o_tdata = r_tdata;

endmodule

// ===== sv/discovery_frame_responder.sv =====
// Discovery frame responder top level.
// Channels: s_axis takes the received UDP payload, one byte per item, tlast on
// the final byte. m_axis returns the reply frame, one byte per item, tlast on
// the final byte; side-effect fields are nonzero only on that final item.
// APB port: eight registers at byte addresses 8*i, 64-bit data, pready tied high.
// Timing: one byte accepted per cycle while receiving. After the final byte the
// block decodes the request in its evaluate state, then loads the first reply
// byte into the output register in its transmit state, and after that sends
// one reply byte per cycle (17 bytes for status replies, 38+NAME_BYTES for
// identify) as long as the receiver takes them; the reply byte counter sets that
// pace. s_axis_tready is low from the cycle after the final byte until the last
// reply byte is loaded into the output register. A stalled receiver holds the
// output register and the counter.
// Reset clears all control, header and network state; net mode returns to
// link-local and configuration registers return to zero.
module discovery_frame_responder #(
    parameter int RX_BUFFER_BYTES = 128,
    parameter int NAME_BYTES      = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // rx_byte
    input  logic                          s_axis_tlast,  // rx_last
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tx_byte[7:0], addr_changed[8], new_ip[40:9], new_mask[72:41],
    // new_gw[104:73], new_mode[106:105], led_request[107], led_seconds[115:108],
    // reboot_request[116], zero[119:117]
    output logic [dfr_pkg::TDATA_W-1:0]   m_axis_tdata,
    output logic                          m_axis_tlast,  // tx_last
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dfr_pkg::PADDR_W-1:0]   paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready
);

    localparam int TOT_LEN = dfr_pkg::HDR_LEN + dfr_pkg::ID_PAYLOAD + NAME_BYTES;
    localparam int IDX_W   = $clog2(TOT_LEN);
    localparam int LEN_W   = $clog2(TOT_LEN + 1);

    dfr_pkg::t_cmd     w_cmd;
    logic [IDX_W-1:0]  w_idx;
    logic [LEN_W-1:0]  w_len;
    logic              w_cfg_we;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite;

    dfr_ctrl #(
        .IDX_W (IDX_W),
        .LEN_W (LEN_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (s_axis_tvalid),
        .i_rx_last   (s_axis_tlast),
        .i_tx_ready  (m_axis_tready),
        .i_reply_len (w_len),
        .o_rx_ready  (s_axis_tready),
        .o_tx_valid  (m_axis_tvalid),
        .o_tx_last   (m_axis_tlast),
        .o_idx       (w_idx),
        .o_cmd       (w_cmd)
    );

    dfr_dp #(
        .RX_BUFFER_BYTES (RX_BUFFER_BYTES),
        .NAME_BYTES      (NAME_BYTES),
        .IDX_W           (IDX_W),
        .LEN_W           (LEN_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_idx       (w_idx),
        .i_rx_byte   (s_axis_tdata),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_idx   (paddr[5:3]),
        .i_cfg_wdata (pwdata),
        .o_cfg_rdata (prdata),
        .o_reply_len (w_len),
        .o_tdata     (m_axis_tdata)
    );

endmodule

// ===== sv/dfr_checker.sv =====
// Port-level checks of the discovery frame responder, bound to the top level.
// Depends on discovery_frame_responder_assert.svh and dfr_pkg.
`include "discovery_frame_responder_assert.svh"

module dfr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          s_axis_tlast,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [dfr_pkg::TDATA_W-1:0]   m_axis_tdata,
    input logic                          m_axis_tlast
);

    `DFR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "reply item changed while stalled")
    `DFR_ASSERT_NEXT(a_burst, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "gap inside reply frame")
    `DFR_ASSERT_NEXT(a_eval_stall, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "input taken during decode")
    `DFR_ASSERT_NOW(a_side_last, m_axis_tvalid && !m_axis_tlast, !m_axis_tdata[8] && !m_axis_tdata[107] && !m_axis_tdata[116], "request flag before final byte")

endmodule

bind discovery_frame_responder dfr_checker u_dfr_checker (.*);

// ===== bench/tb.sv =====
// Testbench for discovery_frame_responder: directed and random request datagrams,
// replies predicted in a scoreboard class and checked byte by byte.
// Depends on dfr_pkg and the discovery_frame_responder RTL.
`timescale 1ns / 1ps

module tb;

    localparam int RX_BUF   = 128;
    localparam int NAME_LEN = 16;
    localparam int LIMIT    = 3000;
    localparam logic [31:0] MAGIC_WORD = 32'h504C_4344;

    typedef struct {
        logic [7:0]  data;
        logic        last;
        logic        chg;
        logic [31:0] ip;
        logic [31:0] mask;
        logic [31:0] gw;
        logic [1:0]  mode;
        logic        led;
        logic [7:0]  secs;
        logic        rbt;
    } t_reply_byte;

    class reply_scoreboard;
        t_reply_byte replies_due[$];
        int errors;
        int replies;
        int bytes_out;
        logic [47:0] mac;
        logic [31:0] ll_addr, prod, init_ip, init_mask, init_gw;
        logic [15:0] hw_rev, fw_ver;
        logic [7:0]  rx_cnt;
        logic        hdr_bad;
        logic [7:0]  op;
        logic [15:0] tid;
        logic [47:0] tgt_mac;
        logic [15:0] decl_len;
        logic [7:0]  head [13];
        logic [31:0] cur_ip, cur_mask, cur_gw;
        logic        override;
        logic [1:0]  mode;
        logic [7:0]  fr [54];

        function new();
            errors = 0;
            replies = 0;
            bytes_out = 0;
            mac = '0; ll_addr = '0; prod = '0; init_ip = '0; init_mask = '0; init_gw = '0;
            hw_rev = '0; fw_ver = '0;
            rx_cnt = '0; hdr_bad = 1'b0; op = '0; tid = '0; tgt_mac = '0; decl_len = '0;
            foreach (head[i]) head[i] = '0;
            cur_ip = '0; cur_mask = '0; cur_gw = '0; override = 1'b0;
            mode = dfr_pkg::MODE_LINKLOCAL;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] v);
            case (idx)
                dfr_pkg::REG_MAC:   mac = v[47:0];
                dfr_pkg::REG_LL:    ll_addr = v[31:0];
                dfr_pkg::REG_PROD:  prod = v[31:0];
                dfr_pkg::REG_HWREV: hw_rev = v[15:0];
                dfr_pkg::REG_FWVER: fw_ver = v[15:0];
                dfr_pkg::REG_IP:    init_ip = v[31:0];
                dfr_pkg::REG_MASK:  init_mask = v[31:0];
                default:            init_gw = v[31:0];
            endcase
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function void header(logic [7:0] rop, int plen);
            foreach (fr[i]) fr[i] = '0;
            for (int i = 0; i < 4; i++) fr[i] = MAGIC_WORD[31-8*i -: 8];
            fr[4] = dfr_pkg::VERSION;
            fr[5] = rop;
            fr[6] = tid[15:8];
            fr[7] = tid[7:0];
            for (int i = 0; i < 6; i++) fr[8+i] = mac[47-8*i -: 8];
            fr[14] = 8'(plen >> 8);
            fr[15] = 8'(plen);
        endfunction

        function void note_input(logic [7:0] b, logic last);
            int n, len, plen, pos;
            logic chg, led, rbt;
            logic [7:0] secs, pm;
            logic [31:0] ip, msk, gw;
            t_reply_byte e;
            n = 0; chg = 0; led = 0; rbt = 0; secs = '0;
            if (rx_cnt < RX_BUF) begin
                pos = rx_cnt;
                if (pos < 4) begin
                    if (b != MAGIC_WORD[31-8*pos -: 8]) hdr_bad = 1'b1;
                end else if (pos == 4) begin
                    if (b != dfr_pkg::VERSION) hdr_bad = 1'b1;
                end else if (pos == 5) op = b;
                else if (pos < 8) tid = {tid[7:0], b};
                else if (pos < 14) tgt_mac = {tgt_mac[39:0], b};
                else if (pos < 16) decl_len = {decl_len[7:0], b};
                else if (pos < dfr_pkg::HDR_LEN + dfr_pkg::HEAD_DEPTH)
                    head[pos - dfr_pkg::HDR_LEN] = b;
                rx_cnt = 8'(pos + 1);
            end
            if (!last) return;
            len = rx_cnt;
            if (len >= dfr_pkg::HDR_LEN && !hdr_bad && (op & dfr_pkg::RESP_BIT) == 0 &&
                (tgt_mac == 0 || tgt_mac == mac)) begin
                plen = decl_len;
                if (dfr_pkg::HDR_LEN + plen > len) plen = len - dfr_pkg::HDR_LEN;
                case (op)
                    dfr_pkg::OP_IDENTIFY: begin
                        header(op | dfr_pkg::RESP_BIT, dfr_pkg::ID_PAYLOAD + NAME_LEN);
                        ip  = override ? cur_ip : init_ip;
                        msk = override ? cur_mask : init_mask;
                        gw  = override ? cur_gw : init_gw;
                        for (int i = 0; i < 4; i++) begin
                            fr[16+i] = prod[31-8*i -: 8];
                            fr[26+i] = ip[31-8*i -: 8];
                            fr[30+i] = msk[31-8*i -: 8];
                            fr[34+i] = gw[31-8*i -: 8];
                        end
                        fr[20] = hw_rev[15:8];
                        fr[21] = hw_rev[7:0];
                        fr[22] = fw_ver[15:8];
                        fr[23] = fw_ver[7:0];
                        fr[24] = {6'b0, mode};
                        fr[25] = 8'd1;
                        n = dfr_pkg::HDR_LEN + dfr_pkg::ID_PAYLOAD + NAME_LEN;
                    end
                    dfr_pkg::OP_SET_NET: begin
                        pm = plen >= 1 ? head[0] : 8'hFF;
                        if (plen >= 1 && pm == dfr_pkg::MODE_LINKLOCAL) begin
                            cur_ip = ll_addr; cur_mask = dfr_pkg::LL_MASK; cur_gw = '0;
                            chg = 1'b1;
                        end else if (plen >= 13 && pm == dfr_pkg::MODE_STATIC) begin
                            cur_ip   = {head[1], head[2], head[3], head[4]};
                            cur_mask = {head[5], head[6], head[7], head[8]};
                            cur_gw   = {head[9], head[10], head[11], head[12]};
                            chg = 1'b1;
                        end
                        if (chg) begin
                            override = 1'b1;
                            mode = pm[1:0];
                        end
                        header(op | dfr_pkg::RESP_BIT, 1);
                        fr[16] = chg ? dfr_pkg::ST_OK : dfr_pkg::ST_ERR;
                        n = dfr_pkg::HDR_LEN + 1;
                    end
                    dfr_pkg::OP_FLASH_LED: begin
                        secs = plen >= 1 ? head[0] : dfr_pkg::LED_DEFAULT;
                        led = 1'b1;
                        header(op | dfr_pkg::RESP_BIT, 1);
                        fr[16] = dfr_pkg::ST_OK;
                        n = dfr_pkg::HDR_LEN + 1;
                    end
                    dfr_pkg::OP_REBOOT: begin
                        rbt = 1'b1;
                        header(op | dfr_pkg::RESP_BIT, 1);
                        fr[16] = dfr_pkg::ST_OK;
                        n = dfr_pkg::HDR_LEN + 1;
                    end
                    dfr_pkg::OP_SET_NAME, dfr_pkg::OP_FACTORY: begin
                        header(op | dfr_pkg::RESP_BIT, 1);
                        fr[16] = dfr_pkg::ST_ERR;
                        n = dfr_pkg::HDR_LEN + 1;
                    end
                    default: n = 0;
                endcase
            end
            for (int k = 0; k < n; k++) begin
                e = '{data: fr[k], last: (k == n - 1), chg: 0, ip: 0, mask: 0, gw: 0,
                      mode: 0, led: 0, secs: 0, rbt: 0};
                if (k == n - 1) begin
                    e.chg = chg;
                    if (chg) begin
                        e.ip = cur_ip; e.mask = cur_mask; e.gw = cur_gw; e.mode = mode;
                    end
                    e.led = led;
                    e.secs = led ? secs : 8'd0;
                    e.rbt = rbt;
                end
                replies_due.push_back(e);
            end
            rx_cnt = '0; hdr_bad = 1'b0; op = '0; tid = '0; tgt_mac = '0; decl_len = '0;
        endfunction

        function void report(string what, logic [127:0] got, logic [127:0] want);
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
            errors++;
        endfunction

        function void check_result(logic [dfr_pkg::TDATA_W-1:0] d, logic last);
            t_reply_byte e;
            if (replies_due.size() == 0) begin
                report("unexpected reply item", 128'(d), 0);
                return;
            end
            e = replies_due.pop_front();
            bytes_out++;
            if (last) replies++;
            if (d[7:0] !== e.data)     report("tx_byte", d[7:0], e.data);
            if (last !== e.last)       report("tx_last", last, e.last);
            if (d[8] !== e.chg)        report("addr_changed", d[8], e.chg);
            if (d[40:9] !== e.ip)      report("new_ip", d[40:9], e.ip);
            if (d[72:41] !== e.mask)   report("new_mask", d[72:41], e.mask);
            if (d[104:73] !== e.gw)    report("new_gw", d[104:73], e.gw);
            if (d[106:105] !== e.mode) report("new_mode", d[106:105], e.mode);
            if (d[107] !== e.led)      report("led_request", d[107], e.led);
            if (d[115:108] !== e.secs) report("led_seconds", d[115:108], e.secs);
            if (d[116] !== e.rbt)      report("reboot_request", d[116], e.rbt);
            if (d[119:117] !== 3'b0)   report("padding", d[119:117], 0);
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [7:0]                    s_tdata;
    logic                          s_tlast;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [dfr_pkg::TDATA_W-1:0]   m_tdata;
    logic                          m_tlast;
    logic                          psel, penable, pwrite;
    logic [dfr_pkg::PADDR_W-1:0]   paddr;
    logic [63:0]                   pwdata;
    logic [63:0]                   prdata;
    logic                          pready;

    reply_scoreboard sb;
    logic [7:0] frame_q[$];
    bit  no_gaps;
    bit  hold_req;
    int  idle_cycles;
    int  bytes_in;
    int  frames_in;

    discovery_frame_responder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", LIMIT);
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        int g;
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (300) @(negedge i_clk);
            end else begin
                g = pick_gap();
                if (g > 0) begin
                    m_tready <= 1'b0;
                    repeat (g) @(negedge i_clk);
                end
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int g;
        g = pick_gap();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_input(b, last);
        bytes_in++;
        @(negedge i_clk);
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
        frames_in++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_config(input int kind);
        logic [63:0] v;
        drain();
        for (int i = 0; i < 8; i++) begin
            case (kind)
                0:       v = '0;
                1:       v = '1;
                default: v = {$urandom, $urandom};
            endcase
            apb_write(3'(i), v);
        end
    endtask

    task automatic build_frame(input logic [7:0] op, input logic [47:0] mac,
                               input int dlen, input int plen, input int first);
        logic [15:0] tid;
        tid = 16'($urandom);
        frame_q.delete();
        for (int i = 0; i < 4; i++) frame_q.push_back(MAGIC_WORD[31-8*i -: 8]);
        frame_q.push_back(dfr_pkg::VERSION);
        frame_q.push_back(op);
        frame_q.push_back(tid[15:8]);
        frame_q.push_back(tid[7:0]);
        for (int i = 0; i < 6; i++) frame_q.push_back(mac[47-8*i -: 8]);
        frame_q.push_back(8'(dlen >> 8));
        frame_q.push_back(8'(dlen));
        for (int i = 0; i < plen; i++)
            frame_q.push_back((i == 0 && first >= 0) ? 8'(first) : 8'($urandom));
    endtask

    function automatic logic [47:0] foreign_mac();
        logic [47:0] m;
        do m = {16'($urandom), $urandom}; while (m == 0 || m == sb.mac);
        return m;
    endfunction

    task automatic rand_frame();
        logic [7:0] op;
        logic [47:0] mac;
        int r, plen, dlen, first;
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 5))
            0: op = dfr_pkg::OP_IDENTIFY;
            1, 2: op = dfr_pkg::OP_SET_NET;
            3: op = dfr_pkg::OP_FLASH_LED;
            4: op = dfr_pkg::OP_REBOOT;
            default: op = ($urandom_range(0, 1) != 0) ? dfr_pkg::OP_SET_NAME
                                                      : dfr_pkg::OP_FACTORY;
        endcase
        mac = ($urandom_range(0, 9) < 7) ? 48'd0 : sb.mac;
        plen = ($urandom_range(0, 29) == 0) ? $urandom_range(100, 180) : $urandom_range(0, 16);
        first = -1;
        if (op == dfr_pkg::OP_SET_NET) begin
            r = $urandom_range(0, 9);
            if (r < 5) begin
                first = dfr_pkg::MODE_STATIC;
                plen = $urandom_range(13, 16);
            end else if (r < 8) first = dfr_pkg::MODE_LINKLOCAL;
            else first = $urandom_range(0, 255);
        end
        r = $urandom_range(0, 9);
        if (r < 7) dlen = plen;
        else if (r < 9) dlen = $urandom_range(0, 65535);
        else dlen = $urandom_range(0, plen);
        build_frame(op, mac, dlen, plen, first);
        r = $urandom_range(0, 99);
        if (r < 4) frame_q[$urandom_range(0, 4)] ^= 8'($urandom_range(1, 255));
        else if (r < 7) frame_q = frame_q[0 : $urandom_range(0, 14)];
        else if (r < 9) frame_q[5] = frame_q[5] | dfr_pkg::RESP_BIT;
        else if (r < 11) frame_q[5] = 8'($urandom_range(7, 127));
        else if (r < 13) begin
            mac = foreign_mac();
            for (int i = 0; i < 6; i++) frame_q[8+i] = mac[47-8*i -: 8];
        end
        send_frame();
    endtask

    initial begin
        int start;
        sb = new();
        i_rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        no_gaps = 1'b0; hold_req = 1'b0;
        idle_cycles = 0; bytes_in = 0; frames_in = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        build_frame(dfr_pkg::OP_IDENTIFY, 48'd0, 0, 0, -1); send_frame();
        load_config(2);
        build_frame(dfr_pkg::OP_IDENTIFY, sb.mac, 0, 0, -1); send_frame();
        build_frame(dfr_pkg::OP_SET_NET, 48'd0, 1, 1, dfr_pkg::MODE_LINKLOCAL); send_frame();
        build_frame(dfr_pkg::OP_IDENTIFY, 48'd0, 0, 0, -1); send_frame();
        build_frame(dfr_pkg::OP_SET_NET, 48'd0, 13, 13, dfr_pkg::MODE_STATIC); send_frame();
        build_frame(dfr_pkg::OP_SET_NET, 48'd0, 12, 12, dfr_pkg::MODE_STATIC); send_frame();
        build_frame(dfr_pkg::OP_SET_NET, 48'd0, 0, 0, -1); send_frame();
        build_frame(dfr_pkg::OP_SET_NET, 48'd0, 13, 13, 1); send_frame();
        build_frame(dfr_pkg::OP_SET_NET, 48'd0, 13, 13, 3); send_frame();
        build_frame(dfr_pkg::OP_IDENTIFY, 48'd0, 0, 0, -1); send_frame();
        build_frame(dfr_pkg::OP_FLASH_LED, 48'd0, 1, 1, 255); send_frame();
        build_frame(dfr_pkg::OP_FLASH_LED, 48'd0, 0, 0, -1); send_frame();
        build_frame(dfr_pkg::OP_REBOOT, 48'd0, 0, 0, -1); send_frame();
        build_frame(dfr_pkg::OP_SET_NAME, 48'd0, 4, 4, -1); send_frame();
        build_frame(dfr_pkg::OP_FACTORY, 48'd0, 0, 0, -1); send_frame();
        build_frame(8'h07, 48'd0, 0, 0, -1); send_frame();
        build_frame(dfr_pkg::OP_IDENTIFY | dfr_pkg::RESP_BIT, 48'd0, 0, 0, -1); send_frame();
        build_frame(dfr_pkg::OP_IDENTIFY, foreign_mac(), 0, 0, -1); send_frame();
        build_frame(dfr_pkg::OP_IDENTIFY, 48'd0, 0, 0, -1);
        frame_q[0] = 8'h00; send_frame();
        build_frame(dfr_pkg::OP_IDENTIFY, 48'd0, 0, 0, -1);
        frame_q[4] = 8'h02; send_frame();
        build_frame(dfr_pkg::OP_IDENTIFY, 48'd0, 0, 0, -1);
        frame_q = frame_q[0:9]; send_frame();
        build_frame(dfr_pkg::OP_FLASH_LED, 48'd0, 16'hFFFF, 0, -1); send_frame();
        build_frame(dfr_pkg::OP_SET_NET, 48'd0, 200, 113, dfr_pkg::MODE_STATIC); send_frame();
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            load_config(phase < 2 ? phase : 2);
            no_gaps = (phase == 1);
            if (phase == 2) begin
                hold_req = 1'b1;
                for (int i = 0; i < 2; i++) begin
                    build_frame(dfr_pkg::OP_IDENTIFY, 48'd0, 0, 0, -1);
                    send_frame();
                end
                drain();
            end
            start = bytes_in;
            while (bytes_in - start < 20) begin
                rand_frame();
                if ($urandom_range(0, 7) == 0) drain();
            end
            drain();
        end
        no_gaps = 1'b0;
        repeat (20) @(negedge i_clk);
        if (sb.pending() != 0) sb.report("replies never sent", sb.pending(), 0);

        $display("covered %0d datagrams with %0d bytes over five register settings",
                 frames_in, bytes_in);
        $display("checked %0d replies, %0d reply bytes", sb.replies, sb.bytes_out);
        if (sb.errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/dfr_pkg.sv
sv/dfr_ctrl.sv
sv/dfr_dp.sv
sv/discovery_frame_responder.sv
sv/dfr_checker.sv
bench/tb.sv
